// File: src/ipv4rx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipv4rx_pkg;

  // Fixed header size; options are not parsed.
  localparam int unsigned HDR_LEN = 20;

  // Header byte offsets.
  localparam logic [4:0] IDX_VERSION   = 5'd0;
  localparam logic [4:0] IDX_TLEN_HI   = 5'd2;
  localparam logic [4:0] IDX_TLEN_LO   = 5'd3;
  localparam logic [4:0] IDX_PROTO     = 5'd9;
  localparam logic [4:0] IDX_CSUM_HI   = 5'd10;
  localparam logic [4:0] IDX_CSUM_LO   = 5'd11;
  localparam logic [4:0] IDX_SRC_0     = 5'd12;
  localparam logic [4:0] IDX_SRC_1     = 5'd13;
  localparam logic [4:0] IDX_SRC_2     = 5'd14;
  localparam logic [4:0] IDX_SRC_3     = 5'd15;
  localparam logic [4:0] IDX_DST_0     = 5'd16;
  localparam logic [4:0] IDX_DST_1     = 5'd17;
  localparam logic [4:0] IDX_DST_2     = 5'd18;
  localparam logic [4:0] IDX_DST_3     = 5'd19;

  // Configuration register indexes.
  localparam logic CFG_LOCAL_IP       = 1'b0;
  localparam logic CFG_HANDLED_PROTOS = 1'b1;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 56;

  typedef enum logic [2:0] {
    VERDICT_ACCEPTED        = 3'd0,
    VERDICT_PROTO_UNHANDLED = 3'd1,
    VERDICT_SHORT           = 3'd2,
    VERDICT_BAD_HEADER      = 3'd3,
    VERDICT_BAD_CHECKSUM    = 3'd4,
    VERDICT_NOT_OURS        = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [15:0] frame_len;
    logic [7:0]  rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    verdict_t    verdict;
    logic [7:0]  protocol;
    logic [31:0] source_ip;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// File: src/ipv4rx_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv4rx_in_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                s_valid,
  output logic                     s_ready,
  input  wire ipv4rx_pkg::rx_item_t s_item,
  output logic                     m_valid,
  input  wire logic                m_ready,
  output ipv4rx_pkg::rx_item_t     m_item
);
  import ipv4rx_pkg::*;

  logic     valid_r;
  rx_item_t item_r;

  // The register frees up in the same cycle that its content moves on.
  assign s_ready = !valid_r || m_ready;
  assign m_valid = valid_r;
  assign m_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_valid && s_ready) begin
      valid_r <= 1'b1;
    end else if (m_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item_r <= s_item;
    end
  end

endmodule

`default_nettype wire

// File: src/ipv4rx_hdr.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv4rx_hdr (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 item_fire,
  input  wire ipv4rx_pkg::rx_item_t item,
  input  wire logic [31:0]          local_ip,
  input  wire logic [63:0]          handled_protocols,
  output logic                      res_valid,
  output ipv4rx_pkg::result_t       res
);
  import ipv4rx_pkg::*;

  logic [15:0] byte_index_r,      byte_index_nxt;
  logic [19:0] sum_r,             sum_nxt;
  logic [15:0] stored_checksum_r, stored_checksum_nxt;
  logic        version_ok_r,      version_ok_nxt;
  logic [15:0] total_length_r,    total_length_nxt;
  logic [7:0]  header_protocol_r, header_protocol_nxt;
  logic [31:0] header_source_r,   header_source_nxt;
  logic        dest_match_r,      dest_match_nxt;
  logic        forwarding_r,      forwarding_nxt;

  logic [16:0] idx_inc;
  logic        frame_end;
  logic        in_hdr;
  logic [4:0]  hidx;
  logic [7:0]  b;
  logic [19:0] add;
  logic [16:0] fold1;
  logic [16:0] fold2;
  logic [15:0] csum;
  logic        dest_ok;
  logic        proto_ok;
  verdict_t    verdict;
  logic        fwd;
  logic        lastp;

  always_comb begin
    b         = item.rx_byte;
    idx_inc   = {1'b0, byte_index_r} + 17'd1;
    frame_end = idx_inc >= {1'b0, item.frame_len};
    in_hdr    = byte_index_r < 16'(HDR_LEN);
    hidx      = byte_index_r[4:0];

    byte_index_nxt      = byte_index_r;
    sum_nxt             = sum_r;
    stored_checksum_nxt = stored_checksum_r;
    version_ok_nxt      = version_ok_r;
    total_length_nxt    = total_length_r;
    header_protocol_nxt = header_protocol_r;
    header_source_nxt   = header_source_r;
    dest_match_nxt      = dest_match_r;
    forwarding_nxt      = forwarding_r;

    add      = byte_index_r[0] ? {12'd0, b} : {4'd0, b, 8'd0};
    fold1    = 17'd0;
    fold2    = 17'd0;
    csum     = 16'd0;
    dest_ok  = 1'b0;
    proto_ok = 1'b0;
    verdict  = VERDICT_ACCEPTED;
    fwd      = 1'b0;
    lastp    = 1'b0;

    res_valid = 1'b0;
    res       = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, verdict: VERDICT_ACCEPTED,
                  protocol: 8'd0, source_ip: 32'd0, last: 1'b0};

    if (in_hdr) begin
      // The checksum field itself counts as zero in the sum.
      if (hidx != IDX_CSUM_HI && hidx != IDX_CSUM_LO) begin
        sum_nxt = sum_r + add;
      end
      case (hidx)
        IDX_VERSION: version_ok_nxt = b[7:4] == 4'd4;
        IDX_TLEN_HI: total_length_nxt = {b, total_length_r[7:0]};
        IDX_TLEN_LO: total_length_nxt = {total_length_r[15:8], b};
        IDX_PROTO:   header_protocol_nxt = b;
        IDX_CSUM_HI: stored_checksum_nxt = {b, stored_checksum_r[7:0]};
        IDX_CSUM_LO: stored_checksum_nxt = {stored_checksum_r[15:8], b};
        IDX_SRC_0, IDX_SRC_1, IDX_SRC_2, IDX_SRC_3: begin
          header_source_nxt = {header_source_r[23:0], b};
        end
        IDX_DST_0: if (local_ip[31:24] != b) dest_match_nxt = 1'b0;
        IDX_DST_1: if (local_ip[23:16] != b) dest_match_nxt = 1'b0;
        IDX_DST_2: if (local_ip[15:8] != b) dest_match_nxt = 1'b0;
        IDX_DST_3: if (local_ip[7:0] != b) dest_match_nxt = 1'b0;
        default: ;
      endcase

      if (hidx == IDX_DST_3) begin
        // Ones' complement fold with end-around carry, then complement.
        fold1    = {1'b0, sum_nxt[15:0]} + {13'd0, sum_nxt[19:16]};
        fold2    = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
        csum     = ~fold2[15:0];
        dest_ok  = dest_match_nxt;
        proto_ok = (header_protocol_r[7:6] == 2'd0) &&
                   handled_protocols[header_protocol_r[5:0]];
        if (!version_ok_r || total_length_r < 16'(HDR_LEN) ||
            total_length_r > item.frame_len) begin
          verdict = VERDICT_BAD_HEADER;
        end else if (csum != stored_checksum_r) begin
          verdict = VERDICT_BAD_CHECKSUM;
        end else if (!dest_ok) begin
          verdict = VERDICT_NOT_OURS;
        end else if (!proto_ok) begin
          verdict = VERDICT_PROTO_UNHANDLED;
        end else begin
          verdict = VERDICT_ACCEPTED;
        end
        fwd            = (verdict == VERDICT_ACCEPTED) && (total_length_r > 16'(HDR_LEN));
        forwarding_nxt = fwd;
        res_valid      = 1'b1;
        res.kind       = KIND_VERDICT;
        res.verdict    = verdict;
        res.protocol   = header_protocol_r;
        res.source_ip  = header_source_r;
        res.last       = !fwd;
      end else if (frame_end) begin
        res_valid   = 1'b1;
        res.kind    = KIND_VERDICT;
        res.verdict = VERDICT_SHORT;
        res.last    = 1'b1;
      end
    end else if (forwarding_r && byte_index_r < total_length_r) begin
      // Payload up to the total length; padding beyond it is dropped.
      lastp            = idx_inc == {1'b0, total_length_r};
      res_valid        = 1'b1;
      res.kind         = KIND_PAYLOAD;
      res.payload_byte = b;
      res.last         = lastp;
      if (lastp) begin
        forwarding_nxt = 1'b0;
      end
    end

    if (frame_end) begin
      byte_index_nxt = 16'd0;
      sum_nxt        = 20'd0;
      version_ok_nxt = 1'b0;
      dest_match_nxt = 1'b1;
      forwarding_nxt = 1'b0;
    end else begin
      byte_index_nxt = idx_inc[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r      <= 16'd0;
      sum_r             <= 20'd0;
      stored_checksum_r <= 16'd0;
      version_ok_r      <= 1'b0;
      total_length_r    <= 16'd0;
      header_protocol_r <= 8'd0;
      header_source_r   <= 32'd0;
      dest_match_r      <= 1'b1;
      forwarding_r      <= 1'b0;
    end else if (item_fire) begin
      byte_index_r      <= byte_index_nxt;
      sum_r             <= sum_nxt;
      stored_checksum_r <= stored_checksum_nxt;
      version_ok_r      <= version_ok_nxt;
      total_length_r    <= total_length_nxt;
      header_protocol_r <= header_protocol_nxt;
      header_source_r   <= header_source_nxt;
      dest_match_r      <= dest_match_nxt;
      forwarding_r      <= forwarding_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/ipv4rx_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv4rx_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire ipv4rx_pkg::result_t load_res,
  output logic                     can_take,
  output logic                     m_valid,
  input  wire logic                m_ready,
  output ipv4rx_pkg::result_t      m_res
);
  import ipv4rx_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign can_take = !valid_r || m_ready;
  assign m_valid  = valid_r;
  assign m_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (m_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

endmodule

`default_nettype wire

// File: src/ipv4_receive_header_check.sv
`timescale 1ns / 1ps
`default_nettype none

// IPv4 receive header check.
// The input stream carries one frame byte per item together with the frame's
// byte count. The block parses the fixed 20-byte header (no options), then
// emits one verdict item per frame: accepted, protocol unhandled, short frame,
// bad version or length, bad checksum, or not addressed to local_ip. After an
// accepted verdict the payload bytes up to the header's total length follow,
// one item each; trailing padding and the header bytes produce no items.
// The configuration channel writes local_ip (index 0) and the 64-bit handled
// protocol mask (index 1); it is always ready. The user must write the
// configuration only while idle; the block itself does not enforce it. An item
// passes an input register and is evaluated on its way into the output
// register, where its result is presented to the receiver. One item is
// accepted every cycle while the receiver does not stall; the sustained rate is
// set by the single evaluation step between the two registers. When the
// receiver stalls, the output register holds its result, no item is evaluated,
// and in_tready drops once the input register holds an item. Reset initialises
// all header state and clears the parse position and both configuration registers.
module ipv4_receive_header_check (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // rx_byte[7:0], frame_len[23:8]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // payload_byte[7:0], verdict[10:8], protocol[18:11],
                                       // source_ip[50:19], zero fill[55:51]
  output logic             out_tuser,  // kind: 0 payload byte, 1 verdict
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);
  import ipv4rx_pkg::*;

  logic [31:0] local_ip_r;
  logic [63:0] handled_protocols_r;

  rx_item_t in_item;
  rx_item_t cur_item;
  logic     cur_valid;
  logic     can_take;
  logic     fire;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r          <= 32'd0;
      handled_protocols_r <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOCAL_IP:       local_ip_r <= cfg_data[31:0];
        CFG_HANDLED_PROTOS: handled_protocols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item = '{frame_len: in_tdata[23:8], rx_byte: in_tdata[7:0]};

  // The held item is evaluated when the output register can take its result.
  assign fire = cur_valid && can_take;

  ipv4rx_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_item  (in_item),
    .m_valid (cur_valid),
    .m_ready (can_take),
    .m_item  (cur_item)
  );

  ipv4rx_hdr u_hdr (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_fire         (fire),
    .item              (cur_item),
    .local_ip          (local_ip_r),
    .handled_protocols (handled_protocols_r),
    .res_valid         (res_valid),
    .res               (res)
  );

  ipv4rx_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire && res_valid),
    .load_res (res),
    .can_take (can_take),
    .m_valid  (out_tvalid),
    .m_ready  (out_tready),
    .m_res    (out_res)
  );

  assign out_tdata = {5'd0, out_res.source_ip, out_res.protocol, out_res.verdict,
                      out_res.payload_byte};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

`default_nettype wire
